@@ rtl/lsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lane steering mode controller package
// Codes, constants and shared types of the lane steering mode controller.
// ----------------------------------------------------------------------------
package lsmc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 15;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_STEER_GAIN     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_PIVOT_TICKS    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_HARD_TURN_RATE = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_CRUISE_SPEED   = 3'd5;

  // Event commands.
  localparam logic [2:0] CMD_LEFT_DEV   = 3'd0;
  localparam logic [2:0] CMD_RIGHT_DEV  = 3'd1;
  localparam logic [2:0] CMD_LEFT_KIND  = 3'd2;
  localparam logic [2:0] CMD_RIGHT_KIND = 3'd3;
  localparam logic [2:0] CMD_OBSTACLE   = 3'd4;
  localparam logic [2:0] CMD_PARK       = 3'd5;

  // Park orders.
  localparam logic [3:0] PARK_RF     = 4'd1;
  localparam logic [3:0] PARK_FOLLOW = 4'd8;
  localparam logic [3:0] PARK_STOP   = 4'd9;
  localparam logic [3:0] PARK_END    = 4'd10;

  // Mode flag bit positions.
  localparam int M_RF     = 0;
  localparam int M_LF     = 1;
  localparam int M_LB     = 2;
  localparam int M_RB     = 3;
  localparam int M_FRONT  = 4;
  localparam int M_BACK   = 5;
  localparam int M_ALIGN  = 6;
  localparam int M_FOLLOW = 7;
  localparam int M_STOP   = 8;
  localparam logic [8:0] MASK_STOP = 9'h100;

  // Line kinds, obstacle sides, turn sides and alignment codes.
  localparam logic [1:0] KIND_DASHED     = 2'd1;
  localparam logic [1:0] KIND_CONTINUOUS = 2'd2;
  localparam logic [1:0] OBS_RIGHT       = 2'd1;
  localparam logic [1:0] OBS_LEFT        = 2'd2;
  localparam logic [1:0] SIDE_NONE       = 2'd0;
  localparam logic [1:0] SIDE_LEFT       = 2'd1;
  localparam logic [1:0] SIDE_RIGHT      = 2'd2;
  localparam logic [1:0] ALIGN_LEFT      = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT     = 2'd2;
  localparam logic [1:0] ALIGN_CENTER    = 2'd3;

  // Fixed manoeuvre values.
  localparam logic signed [15:0] PIVOT_STEER = 16'sd112;
  localparam logic signed [15:0] STEER_MAX   = 16'sd32767;
  localparam logic signed [7:0]  CREEP_FWD   = 8'sd1;
  localparam logic signed [7:0]  CREEP_BACK  = -8'sd2;
  localparam logic signed [7:0]  BACK_SPEED  = -8'sd10;
  localparam logic signed [7:0]  SPEED_MIN   = -8'sd128;
  localparam logic signed [7:0]  SPEED_MAX   = 8'sd127;
  localparam logic [23:0]        ROUND_HALF  = 24'd128;

  typedef struct packed {
    logic [14:0]        low_threshold;
    logic [14:0]        high_threshold;
    logic [7:0]         steer_gain;
    logic [7:0]         pivot_ticks;
    logic [14:0]        hard_turn_rate;
    logic signed [7:0]  cruise_speed;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] deviation;
    logic [1:0]         line_kind;
    logic [1:0]         obstacle_side;
    logic [3:0]         park_order;
  } item_t;

  typedef struct packed {
    logic [8:0]         mode_flags;
    logic [1:0]         obstacle_flags;
    logic [1:0]         left_kind;
    logic [1:0]         right_kind;
    logic signed [15:0] steering_hold;
    logic signed [7:0]  speed_hold;
    logic [7:0]         pivot_count;
    logic [1:0]         last_turn_side;
    logic [1:0]         alignment_hold;
  } state_t;

endpackage

@@ rtl/lsmc_if.sv @@
// ----------------------------------------------------------------------------
// Lane steering mode controller channels
// Valid/ready channels for events in and held results out.
// ----------------------------------------------------------------------------
interface lsmc_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [15:0] deviation;
  logic [1:0]         line_kind;
  logic [1:0]         obstacle_side;
  logic [3:0]         park_order;

  modport source (
    output valid, command, deviation, line_kind, obstacle_side, park_order,
    input  ready
  );
  modport sink (
    input  valid, command, deviation, line_kind, obstacle_side, park_order,
    output ready
  );
endinterface

interface lsmc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  speed;
  logic signed [15:0] steering;
  logic [1:0]         alignment;

  modport source (
    output valid, speed, steering, alignment,
    input  ready
  );
  modport sink (
    input  valid, speed, steering, alignment,
    output ready
  );
endinterface

@@ rtl/lsmc_cfg.sv @@
// ----------------------------------------------------------------------------
// Lane steering mode controller configuration registers
// Holds the thresholds, gain, pivot length, turn rate and cruise speed.
// ----------------------------------------------------------------------------
module lsmc_cfg
  import lsmc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= 15'd1760;
      cfg.high_threshold <= 15'd2000;
      cfg.steer_gain     <= 8'd51;
      cfg.pivot_ticks    <= 8'd200;
      cfg.hard_turn_rate <= 15'd160;
      cfg.cruise_speed   <= 8'sd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data;
        REG_STEER_GAIN:     cfg.steer_gain     <= cfg_data[7:0];
        REG_PIVOT_TICKS:    cfg.pivot_ticks    <= cfg_data[7:0];
        REG_HARD_TURN_RATE: cfg.hard_turn_rate <= cfg_data;
        REG_CRUISE_SPEED:   cfg.cruise_speed   <= $signed(cfg_data[7:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/lsmc_decide.sv @@
// ----------------------------------------------------------------------------
// Lane steering mode controller decision logic
// Works out the next controller state from one event and the present state.
// ----------------------------------------------------------------------------
module lsmc_decide
  import lsmc_pkg::*;
(
  input  cfg_t   cfg,
  input  item_t  item,
  input  state_t st,
  output state_t st_next
);

  logic               run;
  logic [1:0]         side;
  logic signed [15:0] dev;
  logic [8:0]         mode;
  logic signed [7:0]  spd;
  logic               below_low;
  logic               above_high;
  logic [14:0]        diff;
  logic [23:0]        prod;
  logic [15:0]        scaled;
  logic signed [15:0] mag;
  logic signed [15:0] hard;

  always_comb begin
    st_next = st;
    run     = 1'b0;
    side    = SIDE_NONE;
    dev     = '0;
    mode    = st.mode_flags;

    case (item.command)
      CMD_LEFT_DEV: begin
        run  = 1'b1;
        side = SIDE_LEFT;
        dev  = item.deviation;
      end
      CMD_RIGHT_DEV: begin
        run  = 1'b1;
        side = SIDE_RIGHT;
        dev  = item.deviation;
      end
      CMD_LEFT_KIND:  st_next.left_kind  = item.line_kind;
      CMD_RIGHT_KIND: st_next.right_kind = item.line_kind;
      CMD_OBSTACLE: begin
        if (item.obstacle_side == OBS_RIGHT) begin
          st_next.obstacle_flags[0] = 1'b1;
        end else if (item.obstacle_side == OBS_LEFT) begin
          st_next.obstacle_flags[1] = 1'b1;
        end
      end
      CMD_PARK: begin
        run = 1'b1;
        if (item.park_order >= PARK_RF && item.park_order <= PARK_FOLLOW) begin
          mode = (mode & ~MASK_STOP) | (9'd1 << (item.park_order - PARK_RF));
        end else if (item.park_order == PARK_STOP) begin
          mode = mode | MASK_STOP;
        end else if (item.park_order == PARK_END) begin
          mode = '0;
        end
      end
      default: begin
      end
    endcase

    below_low  = !dev[15] && (dev != 16'sd0) && (dev[14:0] < cfg.low_threshold);
    above_high = !dev[15] && (dev[14:0] > cfg.high_threshold);
    diff       = mode[M_FOLLOW] ? (dev[14:0] - cfg.high_threshold)
                                : (cfg.low_threshold - dev[14:0]);
    prod       = 24'(diff) * 24'(cfg.steer_gain) + ROUND_HALF;
    scaled     = prod[23:8];
    mag        = scaled[15] ? STEER_MAX : $signed({1'b0, scaled[14:0]});
    hard       = $signed({1'b0, cfg.hard_turn_rate});
    spd        = cfg.cruise_speed;

    if (run) begin
      if (mode[M_STOP]) begin
        st_next.pivot_count = '0;
        spd  = '0;
        mode = MASK_STOP;
      end else if (mode[M_FRONT]) begin
        st_next.steering_hold = '0;
      end else if (mode[M_BACK]) begin
        st_next.steering_hold = '0;
        spd = (cfg.cruise_speed == SPEED_MIN) ? SPEED_MAX : -cfg.cruise_speed;
      end else if (mode[M_RF] || mode[M_LF]) begin
        if (st.pivot_count < cfg.pivot_ticks) begin
          spd = CREEP_FWD;
          st_next.pivot_count = st.pivot_count + 8'd1;
        end
        st_next.steering_hold = mode[M_RF] ? -PIVOT_STEER : PIVOT_STEER;
      end else if (mode[M_LB] || mode[M_RB]) begin
        if (st.pivot_count < cfg.pivot_ticks) begin
          spd = CREEP_BACK;
          st_next.pivot_count = st.pivot_count + 8'd1;
        end else begin
          spd = BACK_SPEED;
        end
        st_next.steering_hold = mode[M_LB] ? -PIVOT_STEER : PIVOT_STEER;
      end else if (mode[M_FOLLOW]) begin
        if (above_high) begin
          if (side == SIDE_LEFT) begin
            st_next.steering_hold = mag;
          end else if (side == SIDE_RIGHT) begin
            st_next.steering_hold = -mag;
          end
        end
      end else if (st.obstacle_flags[0]) begin
        if (st.right_kind == KIND_DASHED) begin
          st_next.steering_hold = -hard;
        end else if (st.right_kind == KIND_CONTINUOUS) begin
          st_next.obstacle_flags[0] = 1'b0;
        end
      end else if (st.obstacle_flags[1]) begin
        if (st.left_kind == KIND_DASHED) begin
          st_next.steering_hold = hard;
        end else if (st.left_kind == KIND_CONTINUOUS) begin
          st_next.obstacle_flags[1] = 1'b0;
        end
      end else begin
        if (below_low) begin
          if (side == SIDE_LEFT) begin
            st_next.steering_hold  = -mag;
            st_next.last_turn_side = SIDE_LEFT;
            st_next.alignment_hold = ALIGN_LEFT;
          end else if (side == SIDE_RIGHT) begin
            st_next.steering_hold  = mag;
            st_next.last_turn_side = SIDE_RIGHT;
            st_next.alignment_hold = ALIGN_RIGHT;
          end
        end else if (dev[15]) begin
          if (side == SIDE_LEFT) begin
            st_next.steering_hold  = hard;
            st_next.last_turn_side = SIDE_LEFT;
            st_next.alignment_hold = ALIGN_LEFT;
          end else if (side == SIDE_RIGHT) begin
            st_next.steering_hold  = -hard;
            st_next.last_turn_side = SIDE_RIGHT;
            st_next.alignment_hold = ALIGN_RIGHT;
          end
        end else if (side == st.last_turn_side) begin
          st_next.alignment_hold = ALIGN_CENTER;
          st_next.steering_hold  = '0;
        end
      end

      if (mode[M_ALIGN]) begin
        if (below_low || dev[15]) begin
          if (side != SIDE_NONE) begin
            st_next.alignment_hold = side;
          end
        end else if (side == st_next.last_turn_side) begin
          st_next.alignment_hold = ALIGN_CENTER;
        end
      end

      st_next.speed_hold = spd;
      st_next.mode_flags = mode;
    end
  end

endmodule

@@ rtl/lane_steering_mode_controller.sv @@
// ----------------------------------------------------------------------------
// Lane steering mode controller
// Reacts to lane, line type, obstacle and park events with held speed,
// steering and alignment commands.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                   Transfers
//  req       in         command, deviation, line_kind,            one event
//                       obstacle_side, park_order
//  rsp       out        speed, steering, alignment                one result
//  cfg_*     in         cfg_index, cfg_data                       one write
//
//  An event is registered on transfer and its result is registered once the
//  result register is free; one event is taken every cycle unless stalled.
//  The rate is set by the single decision stage between the event register
//  and the result register, which also updates the controller state.
//  A stalled result holds the decision stage; req.ready drops only then.
//  Synchronous reset clears all mode, obstacle and held state.
// ----------------------------------------------------------------------------
module lane_steering_mode_controller
  import lsmc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  lsmc_req_if.sink                 req,
  lsmc_rsp_if.source               rsp
);

  cfg_t   cfg;
  item_t  item;
  state_t st;
  state_t st_next;
  logic   item_valid;
  logic   out_valid;
  logic   fire;
  logic signed [7:0]  speed;
  logic signed [15:0] steering;
  logic [1:0]         alignment;

  lsmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsmc_decide u_decide (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next)
  );

  assign fire      = item_valid && (!out_valid || rsp.ready);
  assign req.ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      st         <= '0;
    end else begin
      if (req.ready) begin
        item_valid <= req.valid;
      end
      if (fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.command       <= req.command;
      item.deviation     <= req.deviation;
      item.line_kind     <= req.line_kind;
      item.obstacle_side <= req.obstacle_side;
      item.park_order    <= req.park_order;
    end
    if (fire) begin
      speed     <= st_next.speed_hold;
      steering  <= st_next.steering_hold;
      alignment <= st_next.alignment_hold;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.speed     = speed;
  assign rsp.steering  = steering;
  assign rsp.alignment = alignment;

endmodule
